// ----- src/bmpd_pkg.sv -----
// Package with item types, field codes and status codes for the BMP pixel deframer.
`timescale 1ns / 1ps

package bmpd_pkg;

  localparam logic [31:0] HDR_TOTAL = 32'd54;

  // Header field selects
  localparam logic [2:0] FLD_NONE   = 3'd0;
  localparam logic [2:0] FLD_OFFSET = 3'd1;
  localparam logic [2:0] FLD_WIDTH  = 3'd2;
  localparam logic [2:0] FLD_HEIGHT = 3'd3;
  localparam logic [2:0] FLD_DEPTH  = 3'd4;

  // Final status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_DEPTH    = 3'd2;
  localparam logic [2:0] ST_DIMS     = 3'd3;
  localparam logic [2:0] ST_OFFSET   = 3'd4;
  localparam logic [2:0] ST_MISMATCH = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        has_alpha;
    logic        is_final;
    logic [2:0]  status;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } out_t;

  // Classification of one byte, made from its file position
  typedef struct packed {
    logic [2:0] fld;
    logic [1:0] lane;
    logic       hdr_check;
    logic       in_data;
    logic       step_mul;
    logic       step_scale;
    logic       step_sum;
    logic       short_file;
    logic       pos_max;
  } cls_t;

  typedef struct packed {
    in_t         item;
    logic [31:0] pos;
    cls_t        cls;
  } q_t;

endpackage

// ----- src/bmpd_fifo.sv -----
// Small register FIFO used between the front and back parts and at the result side.
`timescale 1ns / 1ps

module bmpd_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- src/bmpd_front.sv -----
// Front part: counts file bytes and tags each item with its header role.
`timescale 1ns / 1ps

module bmpd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bmpd_pkg::in_t din,
  input  logic          q_full,
  output logic          q_push,
  output bmpd_pkg::q_t  q_data
);
  import bmpd_pkg::*;

  logic [31:0] pos;
  logic [31:0] pos_next;
  logic        accept;
  cls_t        cls;

  assign accept = push && !q_full;
  assign q_push = accept;

  always_comb begin
    cls      = '0;
    cls.fld  = FLD_NONE;
    cls.lane = pos[1:0] - 2'd2;
    if (pos inside {[32'd10:32'd13]}) begin
      cls.fld = FLD_OFFSET;
    end else if (pos inside {[32'd18:32'd21]}) begin
      cls.fld = FLD_WIDTH;
    end else if (pos inside {[32'd22:32'd25]}) begin
      cls.fld = FLD_HEIGHT;
    end else if (pos inside {32'd28, 32'd29}) begin
      cls.fld  = FLD_DEPTH;
      cls.lane = pos[1:0];
    end
    cls.hdr_check  = (pos == HDR_TOTAL - 32'd1);
    cls.in_data    = (pos >= HDR_TOTAL);
    // product of the sizes is built over three bytes after the header fields settle
    cls.step_mul   = (pos == 32'd30);
    cls.step_scale = (pos == 32'd31);
    cls.step_sum   = (pos == 32'd32);
    cls.short_file = (pos < HDR_TOTAL);
    cls.pos_max    = (pos == 32'hFFFF_FFFF);
  end

  assign q_data.item = din;
  assign q_data.pos  = pos;
  assign q_data.cls  = cls;

  always_comb begin
    pos_next = pos;
    if (accept) begin
      if (din.is_last) begin
        pos_next = '0;
      end else if (pos != 32'hFFFF_FFFF) begin
        pos_next = pos + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

// ----- src/bmpd_back.sv -----
// Back part: captures header fields, assembles pixels and forms the final status.
`timescale 1ns / 1ps

module bmpd_back #(
  parameter int MAX_DIM = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  bmpd_pkg::q_t   q_data,
  output logic           q_pop,
  input  logic           o_full,
  output logic           o_push,
  output bmpd_pkg::out_t o_data
);
  import bmpd_pkg::*;

  logic [31:0] data_offset, data_offset_next;
  logic [31:0] hw, hw_next;
  logic [31:0] hh, hh_next;
  logic [15:0] bit_depth, bit_depth_next;
  logic [23:0] chbuf, chbuf_next;
  logic [1:0]  chidx, chidx_next;
  logic [12:0] col, col_next;
  logic [12:0] row, row_next;
  logic [2:0]  err, err_next;
  logic [25:0] prod, prod_next;
  logic [27:0] prod_g, prod_g_next;
  logic [33:0] expected, expected_next;

  logic        go;
  logic [7:0]  b;
  logic        last;
  logic        pix;
  logic        ds4;
  logic        dims_now;
  logic        dims_out;
  logic [12:0] col_inc;
  logic [32:0] fsize;
  logic [2:0]  status;

  assign go    = !q_empty && !o_full;
  assign q_pop = go;
  assign b     = q_data.item.in_byte;
  assign last  = q_data.item.is_last;
  assign fsize = {1'b0, q_data.pos} + 33'd1;

  always_comb begin
    data_offset_next = data_offset;
    hw_next          = hw;
    hh_next          = hh;
    bit_depth_next   = bit_depth;
    chbuf_next       = chbuf;
    chidx_next       = chidx;
    col_next         = col;
    row_next         = row;
    err_next         = err;
    prod_next        = prod;
    prod_g_next      = prod_g;
    expected_next    = expected;
    pix              = 1'b0;
    o_data           = '0;
    status           = ST_OK;
    col_inc          = col + 13'd1;
    ds4              = (bit_depth == 16'd32);
    dims_now         = (hw <= 32'(MAX_DIM)) && (hh <= 32'(MAX_DIM));

    case (q_data.cls.fld)
      FLD_OFFSET: data_offset_next[q_data.cls.lane*8 +: 8] = data_offset[q_data.cls.lane*8 +: 8] | b;
      FLD_WIDTH:  hw_next[q_data.cls.lane*8 +: 8] = hw[q_data.cls.lane*8 +: 8] | b;
      FLD_HEIGHT: hh_next[q_data.cls.lane*8 +: 8] = hh[q_data.cls.lane*8 +: 8] | b;
      FLD_DEPTH:  bit_depth_next[q_data.cls.lane[0]*8 +: 8] =
                    bit_depth[q_data.cls.lane[0]*8 +: 8] | b;
      default: ;
    endcase

    if (q_data.cls.step_mul) begin
      prod_next = hw[12:0] * hh[12:0];
    end
    if (q_data.cls.step_scale) begin
      prod_g_next = ds4 ? {prod, 2'b00} : ({2'b00, prod} + {1'b0, prod, 1'b0});
    end
    if (q_data.cls.step_sum) begin
      expected_next = {2'b00, data_offset} + {6'd0, prod_g};
    end

    if (q_data.cls.hdr_check) begin
      if (bit_depth != 16'd24 && bit_depth != 16'd32) begin
        err_next = ST_DEPTH;
      end else if (!dims_now) begin
        err_next = ST_DIMS;
      end else if (data_offset < HDR_TOTAL) begin
        err_next = ST_OFFSET;
      end else begin
        err_next = ST_OK;
      end
    end else if (q_data.cls.in_data && err == ST_OK && q_data.pos >= data_offset &&
                 hw != 32'd0 && {19'd0, row} < hh) begin
      if (chidx == (ds4 ? 2'd3 : 2'd2)) begin
        pix              = 1'b1;
        o_data.blue      = chbuf[7:0];
        o_data.green     = chbuf[15:8];
        o_data.red       = ds4 ? chbuf[23:16] : b;
        o_data.alpha     = ds4 ? b : 8'd0;
        chbuf_next       = '0;
        chidx_next       = '0;
        // advance to the next row once the column count reaches the width
        if (col_inc >= hw[12:0]) begin
          col_next = '0;
          row_next = row + 13'd1;
        end else begin
          col_next = col_inc;
        end
      end else begin
        case (chidx)
          2'd0:    chbuf_next[7:0]   = chbuf[7:0] | b;
          2'd1:    chbuf_next[15:8]  = chbuf[15:8] | b;
          2'd2:    chbuf_next[23:16] = chbuf[23:16] | b;
          default: ;
        endcase
        chidx_next = chidx + 2'd1;
      end
    end

    if (q_data.cls.short_file) begin
      status = ST_SHORT;
    end else if (err_next != ST_OK) begin
      status = err_next;
    end else if (q_data.cls.pos_max || {1'b0, fsize} != expected) begin
      status = ST_MISMATCH;
    end

    dims_out            = (hw_next <= 32'(MAX_DIM)) && (hh_next <= 32'(MAX_DIM));
    o_data.pixel_valid  = pix;
    o_data.has_alpha    = (bit_depth_next == 16'd32);
    o_data.is_final     = last;
    o_data.status       = last ? status : ST_OK;
    o_data.image_width  = dims_out ? hw_next[12:0] : 13'd0;
    o_data.image_height = dims_out ? hh_next[12:0] : 13'd0;

    // drop all file state after the last byte
    if (last) begin
      data_offset_next = '0;
      hw_next          = '0;
      hh_next          = '0;
      bit_depth_next   = '0;
      chbuf_next       = '0;
      chidx_next       = '0;
      col_next         = '0;
      row_next         = '0;
      err_next         = ST_OK;
      prod_next        = '0;
      prod_g_next      = '0;
      expected_next    = '0;
    end
  end

  assign o_push = go && (pix || last);

  always_ff @(posedge clk) begin
    if (rst) begin
      data_offset <= '0;
      hw          <= '0;
      hh          <= '0;
      bit_depth   <= '0;
      chbuf       <= '0;
      chidx       <= '0;
      col         <= '0;
      row         <= '0;
      err         <= ST_OK;
      prod        <= '0;
      prod_g      <= '0;
      expected    <= '0;
    end else if (go) begin
      data_offset <= data_offset_next;
      hw          <= hw_next;
      hh          <= hh_next;
      bit_depth   <= bit_depth_next;
      chbuf       <= chbuf_next;
      chidx       <= chidx_next;
      col         <= col_next;
      row         <= row_next;
      err         <= err_next;
      prod        <= prod_next;
      prod_g      <= prod_g_next;
      expected    <= expected_next;
    end
  end

endmodule

// ----- src/bmp_stream_pixel_deframer.sv -----
// Top level of the BMP stream pixel deframer.
//
// Feed a 24- or 32-bit uncompressed BMP file one byte per item on din, with
// is_last set on the final byte. Push an item while full is low. Results come
// out as a queue: while empty is low, dout holds the oldest result; pop it.
// A result appears for each completed pixel and one for the last byte, which
// carries is_final and the file status. Pixels come before the status; drop
// them if the status is not ok.
// A byte taken at an edge is registered in the front-to-back queue; the back
// part reads it there and registers its result in the result queue, where it
// can be popped. Throughput: one byte per cycle while the result queue is not
// full, set by the back part, which handles one queued byte per cycle; the
// product of width, height and pixel size is built over bytes 30 to 32 so no
// wide arithmetic sits on the byte path. Reset clears all state; the block
// also returns to that state after every last byte, ready for the next file.
// When pop stays low, the result queue and then the inner queue fill (two
// items each) and full rises.
`timescale 1ns / 1ps

module bmp_stream_pixel_deframer #(
  parameter int MAX_DIM = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  bmpd_pkg::in_t  din,
  input  logic           pop,
  output logic           empty,
  output bmpd_pkg::out_t dout
);
  import bmpd_pkg::*;

  q_t   fq_wdata;
  q_t   fq_rdata;
  logic fq_push;
  logic fq_full;
  logic fq_pop;
  logic fq_empty;
  out_t rq_wdata;
  logic rq_push;
  logic rq_full;

  assign full = fq_full;

  bmpd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (din),
    .q_full (fq_full),
    .q_push (fq_push),
    .q_data (fq_wdata)
  );

  bmpd_fifo #(
    .W     ($bits(q_t)),
    .DEPTH (2)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  bmpd_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (fq_empty),
    .q_data  (fq_rdata),
    .q_pop   (fq_pop),
    .o_full  (rq_full),
    .o_push  (rq_push),
    .o_data  (rq_wdata)
  );

  bmpd_fifo #(
    .W     ($bits(out_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .wdata (rq_wdata),
    .full  (rq_full),
    .pop   (pop),
    .rdata (dout),
    .empty (empty)
  );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the BMP pixel deframer: whole files in, pixels and status out.
`timescale 1ns / 1ps

module testbench;
  import bmpd_pkg::*;

  localparam int MAX_DIM = 4096;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_BYTES = 150;

  // Tracks header fields and pixel grouping per file, queues the expected results.
  class deframe_checker;
    bit [31:0] pos;
    bit [31:0] offset;
    bit [31:0] width;
    bit [31:0] height;
    bit [15:0] depth;
    bit [23:0] grp;
    bit [1:0]  chan;
    bit [31:0] cols;
    bit [31:0] rows;
    bit [2:0]  verdict;
    out_t      pending_results[$];
    int        errors;
    int        pixels;
    int        finals_by_status[8];

    function void clear_file();
      pos = 0; offset = 0; width = 0; height = 0; depth = 0;
      grp = 0; chan = 0; cols = 0; rows = 0; verdict = ST_OK;
    endfunction

    function bit dims_ok();
      return width <= MAX_DIM && height <= MAX_DIM;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      bit [31:0] p;
      bit [31:0] gs;
      bit [63:0] want;
      bit [2:0]  st;
      bit        pix;
      out_t      e;
      p = pos;
      pix = 1'b0;
      st = ST_OK;
      e = '0;
      if (p >= 10 && p <= 13) offset[8*(p-10) +: 8] = b;
      else if (p >= 18 && p <= 21) width[8*(p-18) +: 8] = b;
      else if (p >= 22 && p <= 25) height[8*(p-22) +: 8] = b;
      else if (p == 28 || p == 29) depth[8*(p-28) +: 8] = b;
      gs = (depth == 16'd32) ? 32'd4 : 32'd3;

      if (p == HDR_TOTAL - 1) begin
        if (depth != 16'd24 && depth != 16'd32) verdict = ST_DEPTH;
        else if (!dims_ok()) verdict = ST_DIMS;
        else if (offset < HDR_TOTAL) verdict = ST_OFFSET;
        else verdict = ST_OK;
      end else if (p >= HDR_TOTAL && verdict == ST_OK && p >= offset && width != 0 &&
                   rows < height) begin
        if (chan == gs - 1) begin
          e.blue = grp[7:0];
          e.green = grp[15:8];
          if (gs == 4) begin
            e.red = grp[23:16];
            e.alpha = b;
          end else begin
            e.red = b;
          end
          pix = 1'b1;
          grp = '0;
          chan = 0;
          cols++;
          if (cols >= width) begin
            cols = 0;
            rows++;
          end
        end else begin
          grp[8*chan +: 8] = b;
          chan++;
        end
      end

      if (pos != 32'hFFFF_FFFF) pos++;

      if (last) begin
        if (64'(p) + 1 <= 64'(HDR_TOTAL)) st = ST_SHORT;
        else if (verdict != ST_OK) st = verdict;
        else begin
          want = 64'(offset) + 64'(width) * 64'(height) * 64'(gs);
          if (p == 32'hFFFF_FFFF || 64'(p) + 1 != want) st = ST_MISMATCH;
        end
      end

      if (pix || last) begin
        e.pixel_valid = pix;
        e.has_alpha = (depth == 16'd32);
        e.is_final = last;
        e.status = st;
        e.image_width = dims_ok() ? width[12:0] : 13'd0;
        e.image_height = dims_ok() ? height[12:0] : 13'd0;
        pending_results.push_back(e);
      end
      if (last) clear_file();
    endfunction

    function string show(out_t r);
      return $sformatf("pix=%0d r=%02h g=%02h b=%02h a=%02h ha=%0d fin=%0d st=%0d w=%0d h=%0d",
                       r.pixel_valid, r.red, r.green, r.blue, r.alpha, r.has_alpha,
                       r.is_final, r.status, r.image_width, r.image_height);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %s", show(got));
        return;
      end
      e = pending_results.pop_front();
      if (got.pixel_valid !== e.pixel_valid || got.red !== e.red || got.green !== e.green ||
          got.blue !== e.blue || got.alpha !== e.alpha || got.has_alpha !== e.has_alpha ||
          got.is_final !== e.is_final || got.status !== e.status ||
          got.image_width !== e.image_width || got.image_height !== e.image_height) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch %0d at %0t", errors, $realtime);
          $display("  expected %s", show(e));
          $display("  actual   %s", show(got));
        end
      end
      if (e.pixel_valid) pixels++;
      if (e.is_final) finals_by_status[e.status]++;
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   push;
  logic   full;
  in_t    din;
  logic   pop = 1'b0;
  logic   empty;
  out_t   dout;

  deframe_checker sb = new();

  logic [7:0] file_bytes[$];
  int         burst_left = 0;
  int         pop_left = 0;
  bit         pop_on = 1'b0;
  int         cycle_count = 0;
  int         random_bytes = 0;
  int         pick;
  int         n;
  int         delta;
  bit [31:0]  f_off;
  bit [31:0]  f_w;
  bit [31:0]  f_h;
  bit [15:0]  f_depth;

  bmp_stream_pixel_deframer #(.MAX_DIM(MAX_DIM)) dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .din   (din),
    .pop   (pop),
    .empty (empty),
    .dout  (dout)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: alternate pop runs and stalls, with occasional long runs of no stall.
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop_left == 0) begin
        pop_on = !pop_on;
        if (pop_on) pop_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                          : $urandom_range(1, 12);
        else pop_left = $urandom_range(1, 6);
      end
      pop_left--;
      pop <= pop_on;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(dout);
  end

  // Sender: bursts of random length separated by short gaps.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    push <= 1'b1;
    din <= '{in_byte: b, is_last: last};
    do @(posedge clk); while (full);
    sb.take_byte(b, last);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
  endtask

  // Hold off the sender until every expected result has been popped.
  task automatic wait_settled();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Header with the given fields, random filler elsewhere, then data bytes.
  // A negative fill value means random data.
  function automatic void make_file(bit [31:0] off, bit [31:0] w, bit [31:0] h,
                                    bit [15:0] dep, int data_len, int fill);
    file_bytes.delete();
    repeat (54) file_bytes.push_back(8'($urandom_range(0, 255)));
    for (int k = 0; k < 4; k++) begin
      file_bytes[10+k] = off[8*k +: 8];
      file_bytes[18+k] = w[8*k +: 8];
      file_bytes[22+k] = h[8*k +: 8];
    end
    file_bytes[28] = dep[7:0];
    file_bytes[29] = dep[15:8];
    repeat (data_len) file_bytes.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
  endfunction

  function automatic int exact_data(bit [31:0] off, bit [31:0] w, bit [31:0] h,
                                    bit [15:0] dep);
    return int'(off) - 54 + int'(w) * int'(h) * ((dep == 16'd32) ? 4 : 3);
  endfunction

  initial begin
    rst = 1'b1;
    push = 1'b0;
    din = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed files
    file_bytes.delete();
    file_bytes.push_back(8'hA5);
    send_file();                                        // one-byte file
    make_file(54, 2, 2, 24, 0, -1);
    send_file();                                        // header only: too short
    make_file(54, 2, 2, 24, 12, 8'hFF);
    send_file();
    make_file(56, 3, 1, 32, 14, -1);
    send_file();
    make_file(55, 0, MAX_DIM, 24, 1, -1);
    send_file();                                        // zero width
    make_file(60, MAX_DIM, 0, 32, 6, -1);
    send_file();                                        // zero height
    wait_settled();
    make_file(54, MAX_DIM, 1, 24, 24, -1);
    send_file();                                        // full-width row, cut short
    make_file(54, MAX_DIM + 1, 1, 24, 9, -1);
    send_file();
    make_file(54, 1, 32'hFFFF_FFFF, 24, 9, -1);
    send_file();                                        // negative height
    make_file(54, 1, 1, 16'h0118, 3, -1);
    send_file();                                        // depth high byte set
    make_file(53, 1, 1, 24, 3, -1);
    send_file();
    make_file(40, 5000, 1, 8, 4, -1);
    send_file();                                        // depth beats dims and offset
    make_file(20, 5000, 1, 32, 4, -1);
    send_file();                                        // dims beat offset
    make_file(32'hFFFF_FFFF, 1, 1, 24, 10, -1);
    send_file();                                        // offset past end of file
    wait_settled();

    // Random files, mostly well-formed
    while (random_bytes < RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      f_depth = $urandom_range(0, 1) ? 16'd32 : 16'd24;
      f_w = $urandom_range(0, 4);
      f_h = $urandom_range(0, 4);
      f_off = 54 + $urandom_range(0, 4);
      n = $urandom_range(0, 20);
      if (pick < 55) begin
        make_file(f_off, f_w, f_h, f_depth, exact_data(f_off, f_w, f_h, f_depth), -1);
      end else if (pick < 65) begin
        delta = $urandom_range(1, 6);
        if ($urandom_range(0, 1)) delta = -delta;
        if ($urandom_range(0, 4) == 0) f_off = $urandom;
        n = exact_data(f_off, f_w, f_h, f_depth) + delta;
        make_file(f_off, f_w, f_h, f_depth, (n < 0 || n > 200) ? 8 : n, -1);
      end else if (pick < 73) begin
        make_file(f_off, f_w, f_h, f_depth, 0, -1);
        n = $urandom_range(1, 54);
        while (file_bytes.size() > n) void'(file_bytes.pop_back());
      end else if (pick < 80) begin
        f_depth = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                       : 16'($urandom_range(0, 40));
        if (f_depth == 16'd24 || f_depth == 16'd32) f_depth = 16'd33;
        make_file(f_off, f_w, f_h, f_depth, n, -1);
      end else if (pick < 87) begin
        case ($urandom_range(0, 2))
          0: f_w = $urandom_range(MAX_DIM + 1, 8191);
          1: f_h = $urandom | 32'h8000_0000;
          default: begin
            f_w = $urandom | 32'h0001_0000;
            f_h = $urandom_range(MAX_DIM + 1, 65535);
          end
        endcase
        make_file(f_off, f_w, f_h, f_depth, n, -1);
      end else if (pick < 93) begin
        f_off = $urandom_range(0, 53);
        make_file(f_off, f_w, f_h, f_depth, n, -1);
      end else begin
        file_bytes.delete();
        repeat ($urandom_range(55, 100)) file_bytes.push_back(8'($urandom_range(0, 255)));
      end
      random_bytes += file_bytes.size();
      send_file();
      if ($urandom_range(0, 5) == 0) wait_settled();
    end

    wait_settled();
    repeat (8) @(posedge clk);

    $display("covered %0d pixels over %0d files; final status ok/short/depth/dims/offset/size:",
             sb.pixels, sb.finals_by_status.sum());
    $display("  %0d/%0d/%0d/%0d/%0d/%0d, %0d check errors",
             sb.finals_by_status[ST_OK], sb.finals_by_status[ST_SHORT],
             sb.finals_by_status[ST_DEPTH], sb.finals_by_status[ST_DIMS],
             sb.finals_by_status[ST_OFFSET], sb.finals_by_status[ST_MISMATCH], sb.errors);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- bmp_stream_pixel_deframer.f -----
src/bmpd_pkg.sv
src/bmpd_fifo.sv
src/bmpd_front.sv
src/bmpd_back.sv
src/bmp_stream_pixel_deframer.sv
bench/testbench.sv
